// ----- hw/rtl/smmh_pkg.sv -----
// ----------------------------------------------------------------------------
// Symmetric min-max heap package
// Shared constants and request, status and command codes.
// ----------------------------------------------------------------------------
package smmh_pkg;

  localparam int DefCapacity  = 1024;
  localparam int DefDataWidth = 32;
  localparam int ValueWidth   = 32;
  localparam int CountWidth   = 11;

  localparam logic [1:0] ReqInsert = 2'd0;
  localparam logic [1:0] ReqRemMin = 2'd1;
  localparam logic [1:0] ReqRemMax = 2'd2;

  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatEmpty = 2'd1;
  localparam logic [1:0] StatFull  = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RD_A,
    CMD_RD_B,
    CMD_INS_SIB,
    CMD_INS_UP,
    CMD_INS_DONE,
    CMD_RM_START,
    CMD_RM_TOP,
    CMD_SINK_C1,
    CMD_SINK_C2,
    CMD_SINK_SIB,
    CMD_SINK_STEP,
    CMD_SINK_DONE,
    CMD_RESULT
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic ins_sib;
    logic ins_go;
    logic ins_up_go;
    logic sink_go;
    logic c2_ok;
    logic sib_ok;
    logic cont;
  } stat_t;

endpackage

// ----- hw/rtl/symmetric_min_max_heap_top.sv -----
// ----------------------------------------------------------------------------
// Symmetric min-max heap top level
// Double-ended priority queue of signed values.
// ----------------------------------------------------------------------------
// A request on the in_ channel inserts in_value, removes the minimum or
// removes the maximum. Each request gives one result on the out_ channel:
// the removed value, a status and the new count.
// Requests are handled one at a time through the heap memory, which has
// one read port and one write port. After an insert is accepted, out_valid
// rises once the new value has been placed against its sibling and has
// climbed level by level to its place. A removal takes out the top value,
// then sinks the last element level by level before out_valid rises. A
// request that is refused or ignored is answered without a heap walk. The next
// request is accepted no earlier than the cycle after the result is delivered.
// Reset empties the heap at once; the memory needs no clearing.
// A result waits in its register while out_ready is low, and no new
// request is taken until it is delivered.
// ----------------------------------------------------------------------------
module symmetric_min_max_heap_top import smmh_pkg::*; #(
  parameter int CAPACITY   = DefCapacity,
  parameter int DATA_WIDTH = DefDataWidth
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_req_type,
  input  logic [ValueWidth-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ValueWidth-1:0] out_removed_value,
  output logic [1:0]            out_status,
  output logic [CountWidth-1:0] out_item_count
);

  cmd_t  cmd;
  stat_t stat;

  smmh_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_req_type,
    .out_valid, .out_ready, .stat, .cmd
  );

  smmh_datapath #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk, .rst_n, .cmd, .in_req_type, .in_value, .stat,
    .res_value(out_removed_value), .res_status(out_status),
    .res_count(out_item_count)
  );

endmodule

// ----- hw/rtl/smmh_datapath.sv -----
// ----------------------------------------------------------------------------
// Symmetric min-max heap datapath
// Heap memory, slot pointers, working value and result registers.
// ----------------------------------------------------------------------------
module smmh_datapath import smmh_pkg::*; #(
  parameter int CAPACITY   = DefCapacity,
  parameter int DATA_WIDTH = DefDataWidth
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  input  logic [1:0]             in_req_type,
  input  logic [ValueWidth-1:0]  in_value,
  output stat_t                  stat,
  output logic [ValueWidth-1:0]  res_value,
  output logic [1:0]             res_status,
  output logic [CountWidth-1:0]  res_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int SW = AW + 2;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_r;
  logic [DATA_WIDTH-1:0] a_r, a_nxt;
  logic [DATA_WIDTH-1:0] y_r, y_nxt;
  logic [SW-1:0]         cur_r, cur_nxt, last_r, last_nxt, m_r, m_nxt;
  logic [SW-1:0]         cnt_r, cnt_nxt;
  logic                  mx_r, mx_nxt;
  logic [ValueWidth-1:0] rv_r, rv_nxt;
  logic [1:0]            st_r, st_nxt;
  logic [SW-1:0]         raddr;
  logic                  we;
  logic [SW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [SW-1:0]         c1, c2, lo;

  function automatic logic slt(input logic [DATA_WIDTH-1:0] x,
                               input logic [DATA_WIDTH-1:0] z);
    slt = $signed(x) < $signed(z);
  endfunction

  assign lo = {1'b0, cur_r[SW-1:2], 1'b0};
  assign c1 = mx_r ? {cur_r[SW-2:0], 1'b0} - SW'(1) : {cur_r[SW-2:0], 1'b0};
  assign c2 = c1 + SW'(2);

  always_comb begin
    raddr = cur_r;
    case (cmd)
      CMD_LOAD:      raddr = cnt_r + SW'(1);
      CMD_RD_A:      raddr = cur_r - SW'(1);
      CMD_INS_SIB:   raddr = lo;
      CMD_RD_B:      raddr = lo + SW'(1);
      CMD_INS_UP:    raddr = {1'b0, lo[SW-1:2], 1'b0};
      CMD_RM_START:  raddr = mx_r ? SW'(3) : SW'(2);
      CMD_RM_TOP:    raddr = c1;
      CMD_SINK_C1:   raddr = c2;
      CMD_SINK_STEP: raddr = mx_r ? m_r - SW'(1) : m_r + SW'(1);
      CMD_SINK_SIB:  raddr = c1;
      default:       raddr = cur_r;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[AW'(raddr - SW'(2))];
    if (we) begin
      mem[AW'(waddr - SW'(2))] <= wdata;
    end
  end

  logic take_c2, y_big;
  assign take_c2 = mx_r ? slt(a_r, rd_r) : slt(rd_r, a_r);
  assign y_big   = mx_r ? slt(y_r, rd_r) : slt(rd_r, y_r);

  always_comb begin
    stat.full      = cnt_r >= SW'(CAPACITY);
    stat.empty     = cnt_r == '0;
    stat.ins_sib   = cur_r[0] && slt(y_r, rd_r);
    stat.ins_go    = cur_r >= SW'(4);
    stat.ins_up_go = slt(y_r, a_r) || slt(rd_r, y_r);
    stat.c2_ok     = c2 <= last_r;
    stat.sink_go   = c1 <= last_r;
    stat.sib_ok    = mx_r ? 1'b1 : (m_r + SW'(1) <= last_r);
    stat.cont      = !(mx_r ? !slt(y_r, a_r) : !slt(a_r, y_r));
  end

  always_comb begin
    a_nxt = a_r; y_nxt = y_r; cur_nxt = cur_r; last_nxt = last_r; m_nxt = m_r;
    cnt_nxt = cnt_r; mx_nxt = mx_r; rv_nxt = rv_r; st_nxt = st_r;
    we = 1'b0; waddr = cur_r; wdata = y_r;
    case (cmd)
      CMD_LOAD: begin
        y_nxt = DATA_WIDTH'(in_value); rv_nxt = '0; st_nxt = StatOk;
        cur_nxt = cnt_r + SW'(2);
        mx_nxt = (in_req_type == ReqRemMax) && (cnt_r >= SW'(2));
        if (in_req_type == ReqInsert && stat.full) st_nxt = StatFull;
        if ((in_req_type == ReqRemMin || in_req_type == ReqRemMax) && stat.empty)
          st_nxt = StatEmpty;
      end
      CMD_RD_A: ;
      CMD_INS_SIB: begin
        if (stat.ins_sib) begin
          we = 1'b1; waddr = cur_r; wdata = rd_r; cur_nxt = cur_r - SW'(1);
        end
      end
      CMD_RD_B: a_nxt = rd_r;
      CMD_INS_UP: begin
        if (slt(y_r, a_r)) begin
          we = 1'b1; waddr = cur_r; wdata = a_r; cur_nxt = lo;
        end else if (slt(rd_r, y_r)) begin
          we = 1'b1; waddr = cur_r; wdata = rd_r; cur_nxt = lo + SW'(1);
        end
      end
      CMD_INS_DONE: begin
        we = 1'b1; waddr = cur_r; wdata = y_r; cnt_nxt = cnt_r + SW'(1);
      end
      CMD_RM_START: begin
        y_nxt = rd_r; cnt_nxt = cnt_r - SW'(1); last_nxt = cnt_r;
        cur_nxt = mx_r ? SW'(3) : SW'(2);
      end
      CMD_RM_TOP: rv_nxt = ValueWidth'($signed(rd_r));
      CMD_SINK_C1: begin a_nxt = rd_r; m_nxt = c1; end
      CMD_SINK_C2: begin
        if (stat.c2_ok && take_c2) begin a_nxt = rd_r; m_nxt = c2; end
      end
      CMD_SINK_STEP: begin
        we = 1'b1; waddr = cur_r; wdata = a_r; cur_nxt = m_r;
      end
      CMD_SINK_SIB: begin
        if (stat.sib_ok && y_big) begin
          we = 1'b1; waddr = mx_r ? cur_r - SW'(1) : cur_r + SW'(1);
          wdata = y_r; y_nxt = rd_r;
        end
      end
      CMD_SINK_DONE: begin
        if (cur_r <= last_r) begin we = 1'b1; waddr = cur_r; wdata = y_r; end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    a_r <= a_nxt; y_r <= y_nxt; cur_r <= cur_nxt; last_r <= last_nxt;
    m_r <= m_nxt; mx_r <= mx_nxt; rv_r <= rv_nxt; st_r <= st_nxt;
  end

  assign res_value  = rv_r;
  assign res_status = st_r;
  assign res_count  = CountWidth'(cnt_r);

endmodule

// ----- hw/rtl/smmh_ctrl.sv -----
// ----------------------------------------------------------------------------
// Symmetric min-max heap controller
// Sequences insert and removal walks and runs the request handshake.
// ----------------------------------------------------------------------------
module smmh_ctrl import smmh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  output logic       out_valid,
  input  logic       out_ready,
  input  stat_t      stat,
  output cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_I_SIB, S_I_CHK, S_I_UP, S_I_DONE,
    S_R_START, S_R_TOP, S_K_CHK, S_K_C2, S_K_STEP, S_K_SIB, S_K_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic       ov_r, ov_nxt;
  logic [1:0] req_r, req_nxt;

  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r; ov_nxt = ov_r; req_nxt = req_r; cmd = CMD_NONE;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd = CMD_LOAD; req_nxt = in_req_type; state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_IDLE; ov_nxt = 1'b1;
        if (req_r == ReqInsert && !stat.full) begin
          ov_nxt = 1'b0; cmd = CMD_RD_A; state_nxt = S_I_SIB;
        end else if ((req_r == ReqRemMin || req_r == ReqRemMax) && !stat.empty) begin
          ov_nxt = 1'b0; cmd = CMD_RD_A; state_nxt = S_R_START;
        end
      end
      S_I_SIB: begin cmd = CMD_INS_SIB; state_nxt = S_I_CHK; end
      S_I_CHK: begin
        if (stat.ins_go) begin
          cmd = CMD_RD_B; state_nxt = S_I_UP;
        end else begin
          state_nxt = S_I_DONE;
        end
      end
      S_I_UP: begin
        cmd = CMD_INS_UP;
        state_nxt = stat.ins_up_go ? S_I_CHK : S_I_DONE;
      end
      S_I_DONE: begin cmd = CMD_INS_DONE; state_nxt = S_IDLE; ov_nxt = 1'b1; end
      S_R_START: begin cmd = CMD_RM_START; state_nxt = S_R_TOP; end
      S_R_TOP: begin cmd = CMD_RM_TOP; state_nxt = S_K_CHK; end
      S_K_CHK: begin
        if (stat.sink_go) begin
          cmd = CMD_SINK_C1; state_nxt = S_K_C2;
        end else begin
          state_nxt = S_K_DONE;
        end
      end
      S_K_C2: begin cmd = CMD_SINK_C2; state_nxt = S_K_STEP; end
      S_K_STEP: begin
        if (stat.cont) begin
          cmd = CMD_SINK_STEP; state_nxt = S_K_SIB;
        end else begin
          state_nxt = S_K_DONE;
        end
      end
      S_K_SIB: begin cmd = CMD_SINK_SIB; state_nxt = S_K_CHK; end
      S_K_DONE: begin cmd = CMD_SINK_DONE; state_nxt = S_IDLE; ov_nxt = 1'b1; end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0; req_r <= ReqInsert;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt; req_r <= req_nxt;
    end
  end

endmodule
